// ===== hdl/nmas_pkg.sv =====
// Package: codes, constants, types and helpers of the perceptron neuron.
`timescale 1ns / 1ps

package nmas_pkg;

  localparam int MAX_INPUTS = 64;
  localparam int FRAC_BITS  = 12;

  localparam int SLOT_W     = 7;
  localparam int OPND_W     = 16;
  localparam int FUNC_W     = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SLOPE_W    = 13;
  localparam int RATE_W     = 15;
  localparam int COUNT_W    = 7;

  localparam int ACC_W      = 40;
  localparam int BSUM_W     = 42;
  localparam int V_W        = 30;
  localparam int MUL_A_W    = 30;
  localparam int MUL_B_W    = 19;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int RES_W      = 38;
  localparam int SAT_W      = PROD_W;

  localparam int X_W        = 14;
  localparam int X2_W       = 16;
  localparam int DEN_W      = 19;
  localparam int QUOT_W     = 14;
  localparam int CNT_W      = 4;
  localparam int NUM_W      = 31;

  localparam int ONE        = 1 << FRAC_BITS;
  localparam int HALF       = 1 << (FRAC_BITS - 1);
  localparam int TANH_K     = 27 * ONE;
  localparam int TANH_LIM   = 3 * ONE;

  localparam logic [SLOPE_W-1:0] SLOPE_RESET = SLOPE_W'(41);
  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(41);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

  localparam logic signed [OUT_DATA_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [OUT_DATA_W-1:0] OUT_MIN = 16'sh8000;

  localparam logic [FUNC_W-1:0] FN_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SAMPLE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_GRAD   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ACT_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAKY_SLOPE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT = 3'd3;

  typedef enum logic [1:0] {
    ACT_LINEAR = 2'd0,
    ACT_TANH   = 2'd1,
    ACT_RELU   = 2'd2,
    ACT_LEAKY  = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_UPD,
    S_BIAS,
    S_ACT,
    S_LEAKY,
    S_LRND,
    S_SQ,
    S_X2,
    S_NUM,
    S_DINIT,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic signed [OUT_DATA_W-1:0] value;
    logic                         hit;
  } sat_t;

  function automatic sat_t sat16(input logic signed [SAT_W-1:0] v);
    sat_t r;
    if (v > SAT_W'(OUT_MAX)) begin
      r.value = OUT_MAX;
      r.hit   = 1'b1;
    end else if (v < SAT_W'(OUT_MIN)) begin
      r.value = OUT_MIN;
      r.hit   = 1'b1;
    end else begin
      r.value = OUT_DATA_W'(v);
      r.hit   = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/nmas_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module nmas_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/neuron_mac_activation_sgd.sv =====
// Top level: perceptron neuron with MAC, activation and gradient update.
`timescale 1ns / 1ps

// One neuron in Q4.12 with a weight RAM, a bias register and a 40-bit
// accumulator, driven by a sequencer around a single shared 30x19 multiplier.
// The input channel takes one request at a time and drops ready until it is
// done: a parameter write runs a fetch step, a sample or gradient step a read,
// multiply and update. A pass's last sample adds bias, activation and output
// steps, leaky relu a multiply and rounding, tanh a square, numerator, divider
// setup and a restoring divider, one quotient bit a cycle. Results leave
// through an output register, so a new request is taken while a result waits.
// Weights read as zero until written; no clearing pass is needed after reset.
module neuron_mac_activation_sgd #(
  parameter int MAX_INPUTS = nmas_pkg::MAX_INPUTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [nmas_pkg::IN_DATA_W-1:0]      in_tdata,  // slot[6:0], operand[22:7], pad
  input  logic [nmas_pkg::FUNC_W-1:0]         in_tuser,  // func
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [nmas_pkg::OUT_DATA_W-1:0]     out_tdata, // neuron_out
  output logic                                out_tuser, // clipped
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nmas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nmas_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ADDR_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam logic [nmas_pkg::SLOT_W-1:0]  BIAS_SLOT = nmas_pkg::SLOT_W'(MAX_INPUTS);
  localparam logic [nmas_pkg::COUNT_W-1:0] COUNT_MAX = nmas_pkg::COUNT_W'(MAX_INPUTS);

  nmas_pkg::state_t state_r, state_nxt;

  nmas_pkg::act_t                         act_mode_r;
  logic [nmas_pkg::SLOPE_W-1:0]           leaky_slope_r;
  logic [nmas_pkg::RATE_W-1:0]            learn_rate_r;
  logic [nmas_pkg::COUNT_W-1:0]           input_count_r;

  logic [nmas_pkg::FUNC_W-1:0]            func_r, func_nxt;
  logic [nmas_pkg::SLOT_W-1:0]            slot_r, slot_nxt;
  logic signed [nmas_pkg::OPND_W-1:0]     opnd_r, opnd_nxt;

  logic [MAX_INPUTS-1:0]                  wvalid_r, wvalid_nxt;
  logic signed [nmas_pkg::OPND_W-1:0]     bias_r, bias_nxt;
  logic signed [nmas_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic signed [nmas_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  logic signed [nmas_pkg::V_W-1:0]        v_r, v_nxt;
  logic signed [nmas_pkg::RES_W-1:0]      res_r, res_nxt;
  logic [nmas_pkg::X_W-1:0]               x_r, x_nxt;
  logic                                   neg_r, neg_nxt;
  logic [nmas_pkg::X2_W-1:0]              x2_r, x2_nxt;
  logic [nmas_pkg::DEN_W-1:0]             den_r, den_nxt;
  logic [nmas_pkg::DEN_W-1:0]             rem_r, rem_nxt;
  logic [nmas_pkg::QUOT_W-1:0]            quot_r, quot_nxt;
  logic [nmas_pkg::QUOT_W-1:0]            numlo_r, numlo_nxt;
  logic [nmas_pkg::CNT_W-1:0]             cnt_r, cnt_nxt;

  logic                                   out_valid_r, out_valid_nxt;
  logic signed [nmas_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                                   out_clip_r, out_clip_nxt;

  logic                                   in_acc;
  logic [ADDR_W-1:0]                      idx;
  logic                                   ram_we, ram_re;
  logic [nmas_pkg::OPND_W-1:0]            ram_wdata, ram_rdata;
  logic signed [nmas_pkg::OPND_W-1:0]     pv;
  logic [nmas_pkg::COUNT_W-1:0]           count;
  logic                                   is_weight, is_bias, last_slot, out_free;

  logic signed [nmas_pkg::MUL_A_W-1:0]    mul_a;
  logic signed [nmas_pkg::MUL_B_W-1:0]    mul_b;
  logic signed [nmas_pkg::PROD_W-1:0]     mul_p;
  logic signed [nmas_pkg::PROD_W-1:0]     prod_rnd;
  logic signed [nmas_pkg::ACC_W:0]        acc_sum;
  logic signed [nmas_pkg::BSUM_W-1:0]     bsum;
  logic signed [nmas_pkg::V_W-1:0]        absv;
  logic [nmas_pkg::DEN_W:0]               trial;
  logic                                   q_bit;
  nmas_pkg::sat_t                         grad_sat, out_sat;

  assign in_tready  = (state_r == nmas_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

  assign idx       = slot_r[ADDR_W-1:0];
  assign is_weight = (slot_r < BIAS_SLOT);
  assign is_bias   = (slot_r == BIAS_SLOT);
  assign count     = (input_count_r == '0) ? nmas_pkg::COUNT_W'(1) :
                     (input_count_r > COUNT_MAX) ? COUNT_MAX : input_count_r;
  assign last_slot = (slot_r == nmas_pkg::SLOT_W'(count - nmas_pkg::COUNT_W'(1)));
  assign pv        = is_bias ? bias_r : (wvalid_r[idx] ? ram_rdata : '0);
  assign out_free  = !out_valid_r || out_tready;

  nmas_ram #(
    .WIDTH (nmas_pkg::OPND_W),
    .DEPTH (MAX_INPUTS),
    .ADDR_W(ADDR_W)
  ) u_wram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      nmas_pkg::S_MUL: begin
        if (func_r == nmas_pkg::FN_GRAD) begin
          mul_a = nmas_pkg::MUL_A_W'({1'b0, learn_rate_r});
          mul_b = nmas_pkg::MUL_B_W'(opnd_r);
        end else begin
          mul_a = nmas_pkg::MUL_A_W'(opnd_r);
          mul_b = nmas_pkg::MUL_B_W'(pv);
        end
      end
      nmas_pkg::S_LEAKY: begin
        mul_a = v_r;
        mul_b = nmas_pkg::MUL_B_W'({1'b0, leaky_slope_r});
      end
      nmas_pkg::S_SQ: begin
        mul_a = nmas_pkg::MUL_A_W'({1'b0, x_r});
        mul_b = nmas_pkg::MUL_B_W'({1'b0, x_r});
      end
      nmas_pkg::S_NUM: begin
        mul_a = nmas_pkg::MUL_A_W'({1'b0, x_r});
        mul_b = nmas_pkg::MUL_B_W'(nmas_pkg::TANH_K) + nmas_pkg::MUL_B_W'({1'b0, x2_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = nmas_pkg::PROD_W'(mul_a) * nmas_pkg::PROD_W'(mul_b);
  assign prod_rnd = (prod_r + nmas_pkg::PROD_W'(nmas_pkg::HALF)) >>> nmas_pkg::FRAC_BITS;
  assign acc_sum  = ((slot_r == '0) ? '0 : (nmas_pkg::ACC_W + 1)'(acc_r))
                  + (nmas_pkg::ACC_W + 1)'(prod_r);
  assign bsum     = nmas_pkg::BSUM_W'(acc_r)
                  + (nmas_pkg::BSUM_W'(bias_r) <<< nmas_pkg::FRAC_BITS)
                  + nmas_pkg::BSUM_W'(nmas_pkg::HALF);
  assign absv     = v_r[nmas_pkg::V_W-1] ? -v_r : v_r;
  assign trial    = {rem_r, numlo_r[nmas_pkg::QUOT_W-1]};
  assign q_bit    = (trial >= {1'b0, den_r});
  assign grad_sat = nmas_pkg::sat16(nmas_pkg::SAT_W'(pv) - prod_rnd);
  assign out_sat  = nmas_pkg::sat16(nmas_pkg::SAT_W'(res_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nmas_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = nmas_pkg::S_FETCH;
        end
      end
      nmas_pkg::S_FETCH: begin
        state_nxt = nmas_pkg::S_IDLE;
        if (func_r == nmas_pkg::FN_GRAD && (is_weight || is_bias)) begin
          state_nxt = nmas_pkg::S_MUL;
        end else if (func_r == nmas_pkg::FN_SAMPLE &&
                     slot_r < nmas_pkg::SLOT_W'(count)) begin
          state_nxt = nmas_pkg::S_MUL;
        end
      end
      nmas_pkg::S_MUL: state_nxt = nmas_pkg::S_UPD;
      nmas_pkg::S_UPD: begin
        if (func_r == nmas_pkg::FN_SAMPLE && last_slot) begin
          state_nxt = nmas_pkg::S_BIAS;
        end else begin
          state_nxt = nmas_pkg::S_IDLE;
        end
      end
      nmas_pkg::S_BIAS: state_nxt = nmas_pkg::S_ACT;
      nmas_pkg::S_ACT: begin
        case (act_mode_r)
          nmas_pkg::ACT_LEAKY: begin
            state_nxt = v_r[nmas_pkg::V_W-1] ? nmas_pkg::S_LEAKY : nmas_pkg::S_OUT;
          end
          nmas_pkg::ACT_TANH: begin
            state_nxt = (absv >= nmas_pkg::V_W'(nmas_pkg::TANH_LIM)) ?
                        nmas_pkg::S_OUT : nmas_pkg::S_SQ;
          end
          default: state_nxt = nmas_pkg::S_OUT;
        endcase
      end
      nmas_pkg::S_LEAKY: state_nxt = nmas_pkg::S_LRND;
      nmas_pkg::S_LRND:  state_nxt = nmas_pkg::S_OUT;
      nmas_pkg::S_SQ:    state_nxt = nmas_pkg::S_X2;
      nmas_pkg::S_X2:    state_nxt = nmas_pkg::S_NUM;
      nmas_pkg::S_NUM:   state_nxt = nmas_pkg::S_DINIT;
      nmas_pkg::S_DINIT: state_nxt = nmas_pkg::S_DIV;
      nmas_pkg::S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = nmas_pkg::S_OUT;
        end
      end
      nmas_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = nmas_pkg::S_IDLE;
        end
      end
      default: state_nxt = nmas_pkg::S_IDLE;
    endcase
  end

  // Datapath and control outputs
  always_comb begin
    func_nxt      = func_r;
    slot_nxt      = slot_r;
    opnd_nxt      = opnd_r;
    wvalid_nxt    = wvalid_r;
    bias_nxt      = bias_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    v_nxt         = v_r;
    res_nxt       = res_r;
    x_nxt         = x_r;
    neg_nxt       = neg_r;
    x2_nxt        = x2_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    numlo_nxt     = numlo_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_clip_nxt  = out_clip_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = opnd_r;

    case (state_r)
      nmas_pkg::S_IDLE: begin
        if (in_acc) begin
          func_nxt = in_tuser;
          slot_nxt = in_tdata[nmas_pkg::SLOT_W-1:0];
          opnd_nxt = in_tdata[nmas_pkg::SLOT_W +: nmas_pkg::OPND_W];
        end
      end
      nmas_pkg::S_FETCH: begin
        ram_re = 1'b1;
        if (func_r == nmas_pkg::FN_WRITE) begin
          if (is_weight) begin
            ram_we          = 1'b1;
            wvalid_nxt[idx] = 1'b1;
          end else if (is_bias) begin
            bias_nxt = opnd_r;
          end
        end
      end
      nmas_pkg::S_MUL: prod_nxt = mul_p;
      nmas_pkg::S_UPD: begin
        if (func_r == nmas_pkg::FN_GRAD) begin
          ram_wdata = grad_sat.value;
          if (is_weight) begin
            ram_we          = 1'b1;
            wvalid_nxt[idx] = 1'b1;
          end else begin
            bias_nxt = grad_sat.value;
          end
        end else begin
          if (acc_sum[nmas_pkg::ACC_W] != acc_sum[nmas_pkg::ACC_W-1]) begin
            acc_nxt = acc_sum[nmas_pkg::ACC_W] ?
                      {1'b1, {(nmas_pkg::ACC_W-1){1'b0}}} :
                      {1'b0, {(nmas_pkg::ACC_W-1){1'b1}}};
          end else begin
            acc_nxt = acc_sum[nmas_pkg::ACC_W-1:0];
          end
        end
      end
      nmas_pkg::S_BIAS: v_nxt = nmas_pkg::V_W'(bsum >>> nmas_pkg::FRAC_BITS);
      nmas_pkg::S_ACT: begin
        res_nxt = nmas_pkg::RES_W'(v_r);
        neg_nxt = v_r[nmas_pkg::V_W-1];
        x_nxt   = absv[nmas_pkg::X_W-1:0];
        case (act_mode_r)
          nmas_pkg::ACT_RELU: begin
            if (v_r[nmas_pkg::V_W-1]) begin
              res_nxt = '0;
            end
          end
          nmas_pkg::ACT_TANH: begin
            res_nxt = v_r[nmas_pkg::V_W-1] ? -nmas_pkg::RES_W'(nmas_pkg::ONE) :
                                             nmas_pkg::RES_W'(nmas_pkg::ONE);
          end
          default: res_nxt = nmas_pkg::RES_W'(v_r);
        endcase
      end
      nmas_pkg::S_LEAKY: prod_nxt = mul_p;
      nmas_pkg::S_LRND:  res_nxt  = nmas_pkg::RES_W'(prod_rnd);
      nmas_pkg::S_SQ:    prod_nxt = mul_p;
      nmas_pkg::S_X2:    x2_nxt   = nmas_pkg::X2_W'(prod_r >>> nmas_pkg::FRAC_BITS);
      nmas_pkg::S_NUM: begin
        prod_nxt = mul_p;
        den_nxt  = nmas_pkg::DEN_W'(nmas_pkg::TANH_K)
                 + nmas_pkg::DEN_W'({x2_r, 3'b000}) + nmas_pkg::DEN_W'(x2_r);
      end
      nmas_pkg::S_DINIT: begin
        rem_nxt   = nmas_pkg::DEN_W'(prod_r[nmas_pkg::NUM_W-1:nmas_pkg::QUOT_W]);
        numlo_nxt = prod_r[nmas_pkg::QUOT_W-1:0];
        quot_nxt  = '0;
        cnt_nxt   = nmas_pkg::CNT_W'(nmas_pkg::QUOT_W - 1);
      end
      nmas_pkg::S_DIV: begin
        rem_nxt   = q_bit ? nmas_pkg::DEN_W'(trial - {1'b0, den_r})
                          : trial[nmas_pkg::DEN_W-1:0];
        quot_nxt  = {quot_r[nmas_pkg::QUOT_W-2:0], q_bit};
        numlo_nxt = {numlo_r[nmas_pkg::QUOT_W-2:0], 1'b0};
        cnt_nxt   = cnt_r - nmas_pkg::CNT_W'(1);
        res_nxt   = neg_r ? -nmas_pkg::RES_W'({quot_r[nmas_pkg::QUOT_W-2:0], q_bit}) :
                             nmas_pkg::RES_W'({quot_r[nmas_pkg::QUOT_W-2:0], q_bit});
      end
      nmas_pkg::S_OUT: begin
        if (out_free) begin
          out_data_nxt  = out_sat.value;
          out_clip_nxt  = out_sat.hit;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= nmas_pkg::S_IDLE;
      out_valid_r   <= 1'b0;
      wvalid_r      <= '0;
      bias_r        <= '0;
      acc_r         <= '0;
      act_mode_r    <= nmas_pkg::ACT_LINEAR;
      leaky_slope_r <= nmas_pkg::SLOPE_RESET;
      learn_rate_r  <= nmas_pkg::RATE_RESET;
      input_count_r <= nmas_pkg::COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wvalid_r    <= wvalid_nxt;
      bias_r      <= bias_nxt;
      acc_r       <= acc_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nmas_pkg::REG_ACT_MODE:    act_mode_r    <= nmas_pkg::act_t'(cfg_data[1:0]);
          nmas_pkg::REG_LEAKY_SLOPE: leaky_slope_r <= cfg_data[nmas_pkg::SLOPE_W-1:0];
          nmas_pkg::REG_LEARN_RATE:  learn_rate_r  <= cfg_data[nmas_pkg::RATE_W-1:0];
          nmas_pkg::REG_INPUT_COUNT: input_count_r <= cfg_data[nmas_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    slot_r     <= slot_nxt;
    opnd_r     <= opnd_nxt;
    prod_r     <= prod_nxt;
    v_r        <= v_nxt;
    res_r      <= res_nxt;
    x_r        <= x_nxt;
    neg_r      <= neg_nxt;
    x2_r       <= x2_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quot_r     <= quot_nxt;
    numlo_r    <= numlo_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    out_clip_r <= out_clip_nxt;
  end

endmodule

// ===== hdl/nmas_chk.sv =====
// Port-level checker for the neuron, bound to the top level.
`timescale 1ns / 1ps

module nmas_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [nmas_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [nmas_pkg::FUNC_W-1:0]     in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [nmas_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [nmas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [nmas_pkg::CFG_DATA_W-1:0] cfg_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // drop ready in the cycle after each request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready high right after a request");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata == nmas_pkg::OUT_MAX || out_tdata == nmas_pkg::OUT_MIN))
    else $error("clipped result not at a rail");

  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while idle");

endmodule

bind neuron_mac_activation_sgd nmas_chk u_nmas_chk (.*);

// ===== test/neuron_mac_activation_sgd_test.sv =====
// Testbench: directed and random requests against a predictor of the neuron.
`timescale 1ns / 1ps

module neuron_mac_activation_sgd_test;
  import nmas_pkg::*;

  localparam int ITEM_GOAL     = 850;
  localparam int SETTLE_CYCLES = 40;
  localparam int SCRIPT_LEN    = 37;

  localparam longint ACC_TOP = 64'sh7F_FFFF_FFFF;
  localparam longint ACC_BOT = -ACC_TOP - 1;

  localparam logic [FUNC_W-1:0]    FN_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [SLOT_W-1:0]    BIAS_SLOT    = 7'd64;

  typedef struct packed {
    logic [OUT_DATA_W-1:0] value;
    logic                  clip;
  } neuron_result_t;

  localparam neuron_result_t NO_RESULT = '0;

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [FUNC_W-1:0]     fn;
    logic [CFG_IDX_W-1:0]  idx;
    logic [SLOT_W-1:0]     slot;
    logic [OPND_W-1:0]     value;
    logic                  typed;
    neuron_result_t        want;
  } step_row_t;

  localparam step_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_REG, FN_WRITE,  REG_INPUT_COUNT, 7'd0,   16'd1,    1'b0, NO_RESULT},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd0,   16'h7fff, 1'b1, '{16'h0000, 1'b0}},
    '{ROW_REQ, FN_WRITE,  REG_ACT_MODE,    7'd0,   16'h7fff, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_WRITE,  REG_ACT_MODE,    7'd64,  16'h7fff, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd0,   16'h7fff, 1'b1, '{16'h7fff, 1'b1}},
    '{ROW_REQ, FN_WRITE,  REG_ACT_MODE,    7'd0,   16'h8000, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_WRITE,  REG_ACT_MODE,    7'd64,  16'h8000, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd0,   16'h7fff, 1'b1, '{16'h8000, 1'b1}},
    '{ROW_REG, FN_WRITE,  REG_ACT_MODE,    7'd0,   16'd2,    1'b0, NO_RESULT},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd0,   16'h7fff, 1'b1, '{16'h0000, 1'b0}},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd0,   16'h8000, 1'b1, '{16'h7fff, 1'b1}},
    '{ROW_REG, FN_WRITE,  REG_ACT_MODE,    7'd0,   16'd1,    1'b0, NO_RESULT},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd0,   16'h8000, 1'b1, '{16'h1000, 1'b0}},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd0,   16'h7fff, 1'b1, '{16'hf000, 1'b0}},
    '{ROW_REG, FN_WRITE,  REG_ACT_MODE,    7'd0,   16'd3,    1'b0, NO_RESULT},
    '{ROW_REG, FN_WRITE,  REG_LEAKY_SLOPE, 7'd0,   16'd0,    1'b0, NO_RESULT},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd0,   16'h7fff, 1'b1, '{16'h0000, 1'b0}},
    '{ROW_REG, FN_WRITE,  REG_LEAKY_SLOPE, 7'd0,   16'd4096, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd0,   16'h7fff, 1'b0, NO_RESULT},
    '{ROW_REG, FN_WRITE,  REG_LEARN_RATE,  7'd0,   16'h7fff, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_GRAD,   REG_ACT_MODE,    7'd0,   16'h7fff, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_GRAD,   REG_ACT_MODE,    7'd64,  16'h8000, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_GRAD,   REG_ACT_MODE,    7'd100, 16'h1234, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_WRITE,  REG_ACT_MODE,    7'd127, 16'h5555, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_UNUSED, REG_ACT_MODE,    7'd3,   16'haaaa, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd5,   16'h7fff, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd0,   16'h4000, 1'b0, NO_RESULT},
    '{ROW_REG, FN_WRITE,  REG_INPUT_COUNT, 7'd0,   16'd0,    1'b0, NO_RESULT},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd0,   16'h0001, 1'b0, NO_RESULT},
    '{ROW_REG, FN_WRITE,  REG_SPARE,       7'd0,   16'hffff, 1'b0, NO_RESULT},
    '{ROW_REG, FN_WRITE,  REG_INPUT_COUNT, 7'd0,   16'd2,    1'b0, NO_RESULT},
    '{ROW_REG, FN_WRITE,  REG_ACT_MODE,    7'd0,   16'd0,    1'b0, NO_RESULT},
    '{ROW_REG, FN_WRITE,  REG_LEARN_RATE,  7'd0,   16'd0,    1'b0, NO_RESULT},
    '{ROW_REQ, FN_WRITE,  REG_ACT_MODE,    7'd1,   16'h2000, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd0,   16'h1000, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_SAMPLE, REG_ACT_MODE,    7'd1,   16'hf000, 1'b0, NO_RESULT},
    '{ROW_REQ, FN_GRAD,   REG_ACT_MODE,    7'd1,   16'h7fff, 1'b0, NO_RESULT}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [FUNC_W-1:0]     in_tuser   = FN_WRITE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_ACT_MODE;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  act_t                      act_q    = ACT_LINEAR;
  logic [SLOPE_W-1:0]        slope_q  = SLOPE_RESET;
  logic [RATE_W-1:0]         learn_q  = RATE_RESET;
  logic [COUNT_W-1:0]        in_count = COUNT_RESET;
  logic signed [OPND_W-1:0]  weights_q [MAX_INPUTS] = '{default: '0};
  logic signed [OPND_W-1:0]  bias_q   = '0;
  longint                    acc_q    = 0;

  neuron_result_t due_results [$];
  int             mismatch_cnt = 0;
  int             applied_cnt  = 0;
  bit             calm         = 1'b0;
  int             stall_len    = 0;
  int             stall_seq    = 0;
  int             stall_seen   = 0;
  int             stall_left   = 0;

  neuron_mac_activation_sgd u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint round_q(input longint v);
    return (v + HALF) >>> FRAC_BITS;
  endfunction

  function automatic logic [OUT_DATA_W-1:0] clamp_q(input longint v, output bit hit);
    hit = (v > 32767) || (v < -32768);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return OUT_DATA_W'(v);
  endfunction

  function automatic longint tanh_fit(input longint v);
    longint x, x2, mag;
    x = (v < 0) ? -v : v;
    if (x >= TANH_LIM) begin
      mag = ONE;
    end else begin
      x2  = (x * x) >>> FRAC_BITS;
      mag = (x * (TANH_K + x2)) / (TANH_K + 9 * x2);
    end
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic int effective_span();
    if (in_count == 0) return 1;
    if (in_count > MAX_INPUTS) return MAX_INPUTS;
    return int'(in_count);
  endfunction

  function automatic void neuron_predict(input logic [FUNC_W-1:0] fn,
                                         input logic [SLOT_W-1:0] slot,
                                         input logic signed [OPND_W-1:0] opnd,
                                         output bit live, output bit fires,
                                         output neuron_result_t res);
    int                       span;
    longint                   prod, sum;
    logic signed [OPND_W-1:0] cur;
    bit                       hit;
    live  = 1'b0;
    fires = 1'b0;
    res   = NO_RESULT;
    span  = effective_span();
    if ((fn == FN_WRITE || fn == FN_GRAD) && slot <= MAX_INPUTS) begin
      live = 1'b1;
      cur  = (slot == BIAS_SLOT) ? bias_q : weights_q[slot[5:0]];
      if (fn == FN_GRAD) cur = clamp_q(cur - round_q(longint'(learn_q) * opnd), hit);
      else cur = opnd;
      if (slot == BIAS_SLOT) bias_q = cur;
      else weights_q[slot[5:0]] = cur;
    end else if (fn == FN_SAMPLE && slot < span) begin
      live  = 1'b1;
      prod  = longint'(opnd) * longint'(weights_q[slot[5:0]]);
      acc_q = (slot == 0) ? prod : acc_q + prod;
      if (acc_q > ACC_TOP) acc_q = ACC_TOP;
      if (acc_q < ACC_BOT) acc_q = ACC_BOT;
      if (slot == span - 1) begin
        sum = round_q(acc_q + longint'(bias_q) * ONE);
        case (act_q)
          ACT_TANH: sum = tanh_fit(sum);
          ACT_RELU: if (sum < 0) sum = 0;
          ACT_LEAKY: if (sum < 0) sum = round_q(sum * longint'(slope_q));
          default: ;
        endcase
        res.value = clamp_q(sum, hit);
        res.clip  = hit;
        fires     = 1'b1;
      end
    end
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_cnt++;
    $display("neuron check: %s", what);
  endtask

  task automatic push_request(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] slot,
                              input logic [OPND_W-1:0] opnd, input bit typed,
                              input neuron_result_t want);
    neuron_result_t got;
    bit             live, fires;
    if (!calm && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, opnd, slot};
    in_tuser  <= fn;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    neuron_predict(fn, slot, opnd, live, fires, got);
    if (live) applied_cnt++;
    if (fires) due_results.push_back(typed ? want : got);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ACT_MODE:    act_q    = act_t'(data[1:0]);
      REG_LEAKY_SLOPE: slope_q  = data[SLOPE_W-1:0];
      REG_LEARN_RATE:  learn_q  = data[RATE_W-1:0];
      REG_INPUT_COUNT: in_count = data[COUNT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the input low until every result is back and the sequencer has settled
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [OPND_W-1:0] pick_q412();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return ($urandom_range(1) != 0) ? 16'h7fff : 16'h8000;
    if (r < 50) return 16'(int'($urandom_range(2 * ONE)) - ONE);
    if (r < 75) return 16'(int'($urandom_range(8 * ONE)) - 4 * ONE);
    return 16'($urandom);
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot(input int span);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 7'($urandom_range(span - 1));
    if (r < 85) return BIAS_SLOT;
    return 7'($urandom_range(MAX_INPUTS - 1));
  endfunction

  always @(posedge clk) begin
    if (stall_seq != stall_seen) begin
      stall_seen = stall_seq;
      stall_left = stall_len;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    neuron_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result %h clip %b", out_tdata, out_tuser));
      end else begin
        want = due_results.pop_front();
        if (out_tdata !== want.value || out_tuser !== want.clip)
          note_mismatch($sformatf("result %h clip %b, want %h clip %b",
                                  out_tdata, out_tuser, want.value, want.clip));
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int                    phase, rounds, span, pick;
    logic [CFG_DATA_W-1:0] cfg_word;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(SCRIPT[i].idx, SCRIPT[i].value);
      end else begin
        push_request(SCRIPT[i].fn, SCRIPT[i].slot, SCRIPT[i].value,
                     SCRIPT[i].typed, SCRIPT[i].want);
      end
    end

    phase = 0;
    while (applied_cnt < ITEM_GOAL) begin
      wait_idle();
      calm = (phase == 1);

      cfg_word = ($urandom_range(3) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(int'(ACT_LEAKY)));
      write_reg(REG_ACT_MODE, cfg_word);

      pick = $urandom_range(9);
      if (pick == 0) cfg_word = 16'd0;
      else if (pick == 1) cfg_word = 16'(ONE);
      else if (pick == 2) cfg_word = 16'h1fff;
      else cfg_word = 16'($urandom_range(ONE));
      write_reg(REG_LEAKY_SLOPE, cfg_word);

      pick = $urandom_range(9);
      if (pick == 0) cfg_word = 16'd0;
      else if (pick == 1) cfg_word = 16'h7fff;
      else if (pick < 6) cfg_word = 16'($urandom_range(1024));
      else cfg_word = 16'($urandom_range(32767));
      write_reg(REG_LEARN_RATE, cfg_word);

      pick = $urandom_range(99);
      if (phase == 2 || pick < 70) cfg_word = 16'($urandom_range(1, 8));
      else if (pick < 80) cfg_word = 16'($urandom_range(9, 24));
      else if (pick < 87) cfg_word = 16'(MAX_INPUTS);
      else if (pick < 91) cfg_word = 16'h007f;
      else if (pick < 95) cfg_word = 16'd0;
      else cfg_word = 16'($urandom_range(1, 126));
      if ($urandom_range(7) == 0) cfg_word[15:COUNT_W] = 9'($urandom);
      write_reg(REG_INPUT_COUNT, cfg_word);

      if ($urandom_range(9) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), 16'($urandom));

      span = effective_span();
      if (phase == 2) begin
        stall_len = 400;
        stall_seq++;
      end

      rounds = $urandom_range(2, 5);
      for (int r = 0; r < rounds; r++) begin
        repeat ($urandom_range(4)) push_request(FN_WRITE, pick_slot(span), pick_q412(),
                                               1'b0, NO_RESULT);
        for (int s = 0; s < span; s++) begin
          pick = $urandom_range(99);
          if (pick < 4) break;
          if (pick < 8)
            push_request(FN_SAMPLE, 7'($urandom_range(span - 1)), pick_q412(), 1'b0, NO_RESULT);
          else
            push_request(FN_SAMPLE, 7'(s), pick_q412(), 1'b0, NO_RESULT);
        end
        if ($urandom_range(3) == 0)
          push_request(FN_GRAD, pick_slot(span), pick_q412(), 1'b0, NO_RESULT);
        if ($urandom_range(4) == 0) begin
          case ($urandom_range(2))
            0: push_request(FN_UNUSED, 7'($urandom), 16'($urandom), 1'b0, NO_RESULT);
            1: push_request(($urandom_range(1) != 0) ? FN_WRITE : FN_GRAD,
                            7'($urandom_range(127, MAX_INPUTS + 1)), 16'($urandom),
                            1'b0, NO_RESULT);
            default: push_request(FN_SAMPLE, 7'($urandom_range(127, span)), 16'($urandom),
                                  1'b0, NO_RESULT);
          endcase
        end
      end
      phase++;
    end

    wait_idle();
    calm = 1'b0;
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== neuron_mac_activation_sgd.f =====
hdl/nmas_pkg.sv
hdl/nmas_ram.sv
hdl/neuron_mac_activation_sgd.sv
hdl/nmas_chk.sv
test/neuron_mac_activation_sgd_test.sv
